@@ hw/rtl/csol_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the count-ordered self-organizing list.
// Used by csol_ctrl, csol_datapath and the top level; depends on nothing.

package csol_pkg;

    // Number of list entries the block holds.
    localparam int CAPACITY = 16;

    // Widths that follow from the capacity.
    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);

    // Fixed field widths of the item ports.
    localparam int OP_W   = 3;
    localparam int KEY_W  = 64;
    localparam int SLOT_W = 4;
    localparam int HIT_W  = 32;
    localparam int POS_W  = 4;
    localparam int ITEM_W = 5;

    // Common width for comparing a slot number against the fill count.
    localparam int CMP_W = (SLOT_W > CNT_W) ? SLOT_W : CNT_W;

    localparam logic [HIT_W-1:0] HIT_MAX = '1;

    // Operation codes carried in the opcode field.
    localparam logic [OP_W-1:0] OP_INSERT = 3'd0;
    localparam logic [OP_W-1:0] OP_REMOVE = 3'd1;
    localparam logic [OP_W-1:0] OP_SEARCH = 3'd2;
    localparam logic [OP_W-1:0] OP_CLEAR  = 3'd3;
    localparam logic [OP_W-1:0] OP_READ   = 3'd4;

    // Controller states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_FETCH,
        S_EXEC
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic load;
        logic fetch;
        logic exec;
    } t_dp_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic in_search;
    } t_dp_sts;

endpackage

@@ hw/rtl/csol_ctrl.sv @@
`timescale 1ns / 1ps
// Controller state machine of the count-ordered self-organizing list.
// Depends on csol_pkg for the state type and the command and status structs.

module csol_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    output logic               o_stall,
    output logic               o_valid,
    input  logic               i_stall,
    output csol_pkg::t_dp_cmd  o_cmd,
    input  csol_pkg::t_dp_sts  i_sts
);

    csol_pkg::t_state r_state;
    csol_pkg::t_state n_state;
    logic             r_out_valid;
    logic             n_out_valid;
    logic             accept;
    logic             out_free;

    assign accept   = i_valid && (r_state == csol_pkg::S_IDLE);
    assign out_free = !r_out_valid || !i_stall;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            csol_pkg::S_IDLE: begin
                if (accept) begin
                    n_state = i_sts.in_search ? csol_pkg::S_FETCH : csol_pkg::S_EXEC;
                end
            end
            csol_pkg::S_FETCH: begin
                n_state = csol_pkg::S_EXEC;
            end
            csol_pkg::S_EXEC: begin
                if (out_free) begin
                    n_state = csol_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = csol_pkg::S_IDLE;
            end
        endcase
    end

    // Outputs.
    always_comb begin
        o_stall     = 1'b1;
        o_cmd       = '0;
        unique case (r_state)
            csol_pkg::S_IDLE: begin
                o_stall    = 1'b0;
                o_cmd.load = accept;
            end
            csol_pkg::S_FETCH: begin
                o_cmd.fetch = 1'b1;
            end
            csol_pkg::S_EXEC: begin
                o_cmd.exec = out_free;
            end
            default: begin
                o_stall = 1'b1;
            end
        endcase
    end

    // The result register is full from execution until the item is taken.
    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.exec) begin
            n_out_valid = 1'b1;
        end else if (!i_stall) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= csol_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_valid = r_out_valid;

`ifndef ASSERT_OFF
    a_exec_needs_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.exec |-> (!r_out_valid || !i_stall))
        else $error("execution would overwrite a result that was not taken");
    a_exec_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.exec |=> r_out_valid)
        else $error("execution did not present a result");
    a_fetch_then_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == csol_pkg::S_FETCH) |=> (r_state == csol_pkg::S_EXEC))
        else $error("counter fetch was not followed by execution");
    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state != csol_pkg::S_IDLE))
        else $error("accepted item was not processed");
`endif

endmodule

@@ hw/rtl/csol_datapath.sv @@
`timescale 1ns / 1ps
// Datapath of the count-ordered self-organizing list: the entry cells, the
// fill count, the match and target search, and the result registers. Uses csol_pkg.

module csol_datapath (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  csol_pkg::t_dp_cmd                    i_cmd,
    output csol_pkg::t_dp_sts                    o_sts,
    input  logic        [csol_pkg::OP_W-1:0]     i_opcode,
    input  logic signed [csol_pkg::KEY_W-1:0]    i_key,
    input  logic        [csol_pkg::SLOT_W-1:0]   i_slot_index,
    output logic                                 o_ok,
    output logic        [csol_pkg::POS_W-1:0]    o_position,
    output logic        [csol_pkg::HIT_W-1:0]    o_hit_count,
    output logic signed [csol_pkg::KEY_W-1:0]    o_read_value,
    output logic                                 o_is_empty,
    output logic        [csol_pkg::ITEM_W-1:0]   o_item_count,
    output logic                                 o_is_full
);

    // Entry cells, valid below the fill count only.
    logic signed [csol_pkg::KEY_W-1:0]  r_ent_key  [csol_pkg::CAPACITY];
    logic        [csol_pkg::HIT_W-1:0]  r_ent_hits [csol_pkg::CAPACITY];
    logic signed [csol_pkg::KEY_W-1:0]  n_ent_key  [csol_pkg::CAPACITY];
    logic        [csol_pkg::HIT_W-1:0]  n_ent_hits [csol_pkg::CAPACITY];
    logic        [csol_pkg::CNT_W-1:0]  r_occ;
    logic        [csol_pkg::CNT_W-1:0]  n_occ;

    // Latched item and search results.
    logic        [csol_pkg::OP_W-1:0]   r_op;
    logic signed [csol_pkg::KEY_W-1:0]  r_key;
    logic        [csol_pkg::SLOT_W-1:0] r_slot;
    logic                               r_found;
    logic        [csol_pkg::IDX_W-1:0]  r_idx;
    logic        [csol_pkg::HIT_W-1:0]  r_cnt;

    logic                               m_found;
    logic        [csol_pkg::IDX_W-1:0]  m_idx;
    logic        [csol_pkg::IDX_W-1:0]  tgt_idx;
    logic        [csol_pkg::IDX_W-1:0]  rd_idx;
    logic signed [csol_pkg::KEY_W-1:0]  rd_key;
    logic        [csol_pkg::HIT_W-1:0]  rd_hits;
    logic                               full;
    logic                               slot_hit;

    // Result registers.
    logic                               r_ok;
    logic        [csol_pkg::POS_W-1:0]  r_pos;
    logic        [csol_pkg::HIT_W-1:0]  r_hits_out;
    logic signed [csol_pkg::KEY_W-1:0]  r_rval;
    logic                               n_ok;
    logic        [csol_pkg::POS_W-1:0]  n_pos;
    logic        [csol_pkg::HIT_W-1:0]  n_hits_out;
    logic signed [csol_pkg::KEY_W-1:0]  n_rval;

    assign o_sts.in_search = (i_opcode == csol_pkg::OP_SEARCH);
    assign full     = (r_occ == csol_pkg::CNT_W'(csol_pkg::CAPACITY));
    assign slot_hit = (csol_pkg::CMP_W'(r_slot) < csol_pkg::CMP_W'(r_occ));

    // First valid cell whose key equals the incoming key.
    always_comb begin
        m_found = 1'b0;
        m_idx   = '0;
        for (int c = csol_pkg::CAPACITY - 1; c >= 0; c--) begin
            if ((csol_pkg::CNT_W'(c) < r_occ) && (r_ent_key[c] == i_key)) begin
                m_found = 1'b1;
                m_idx   = csol_pkg::IDX_W'(c);
            end
        end
    end

    // Single read port, shared by the counter fetch and the slot read.
    assign rd_idx  = i_cmd.fetch ? r_idx : csol_pkg::IDX_W'(r_slot);
    assign rd_key  = r_ent_key[rd_idx];
    assign rd_hits = r_ent_hits[rd_idx];

    // First cell ahead of the match whose count does not exceed the new count.
    always_comb begin
        tgt_idx = r_idx;
        for (int c = csol_pkg::CAPACITY - 1; c >= 0; c--) begin
            if ((csol_pkg::IDX_W'(c) < r_idx) && (r_ent_hits[c] <= r_cnt)) begin
                tgt_idx = csol_pkg::IDX_W'(c);
            end
        end
    end

    // Next cell contents.
    always_comb begin
        for (int c = 0; c < csol_pkg::CAPACITY; c++) begin
            n_ent_key[c]  = r_ent_key[c];
            n_ent_hits[c] = r_ent_hits[c];
        end
        if (i_cmd.exec) begin
            case (r_op)
                csol_pkg::OP_INSERT: begin
                    for (int c = 0; c < csol_pkg::CAPACITY; c++) begin
                        if (!full && (csol_pkg::CNT_W'(c) == r_occ)) begin
                            n_ent_key[c]  = r_key;
                            n_ent_hits[c] = '0;
                        end
                    end
                end
                csol_pkg::OP_REMOVE: begin
                    if (r_found) begin
                        for (int c = 0; c < csol_pkg::CAPACITY - 1; c++) begin
                            if (csol_pkg::IDX_W'(c) >= r_idx) begin
                                n_ent_key[c]  = r_ent_key[c + 1];
                                n_ent_hits[c] = r_ent_hits[c + 1];
                            end
                        end
                    end
                end
                csol_pkg::OP_SEARCH: begin
                    if (r_found) begin
                        for (int c = 1; c < csol_pkg::CAPACITY; c++) begin
                            if ((csol_pkg::IDX_W'(c) > tgt_idx) &&
                                (csol_pkg::IDX_W'(c) <= r_idx)) begin
                                n_ent_key[c]  = r_ent_key[c - 1];
                                n_ent_hits[c] = r_ent_hits[c - 1];
                            end
                        end
                        for (int c = 0; c < csol_pkg::CAPACITY; c++) begin
                            if (csol_pkg::IDX_W'(c) == tgt_idx) begin
                                n_ent_key[c]  = r_key;
                                n_ent_hits[c] = r_cnt;
                            end
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    // Next fill count and result fields.
    always_comb begin
        n_occ      = r_occ;
        n_ok       = 1'b0;
        n_pos      = '0;
        n_hits_out = '0;
        n_rval     = '0;
        case (r_op)
            csol_pkg::OP_INSERT: begin
                if (!full) begin
                    n_occ = r_occ + 1'b1;
                    n_ok  = 1'b1;
                    n_pos = csol_pkg::POS_W'(r_occ);
                end
            end
            csol_pkg::OP_REMOVE: begin
                if (r_found) begin
                    n_occ = r_occ - 1'b1;
                    n_ok  = 1'b1;
                end
            end
            csol_pkg::OP_SEARCH: begin
                if (r_found) begin
                    n_ok       = 1'b1;
                    n_pos      = csol_pkg::POS_W'(tgt_idx);
                    n_hits_out = r_cnt;
                end
            end
            csol_pkg::OP_CLEAR: begin
                n_occ = '0;
            end
            csol_pkg::OP_READ: begin
                if (slot_hit) begin
                    n_ok       = 1'b1;
                    n_hits_out = rd_hits;
                    n_rval     = rd_key;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_occ <= '0;
        end else if (i_cmd.exec) begin
            r_occ <= n_occ;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ent_key  <= n_ent_key;
        r_ent_hits <= n_ent_hits;
        if (i_cmd.load) begin
            r_op    <= i_opcode;
            r_key   <= i_key;
            r_slot  <= i_slot_index;
            r_found <= m_found;
            r_idx   <= m_idx;
        end
        if (i_cmd.fetch) begin
            r_cnt <= (rd_hits == csol_pkg::HIT_MAX) ? rd_hits : rd_hits + 1'b1;
        end
        if (i_cmd.exec) begin
            r_ok         <= n_ok;
            r_pos        <= n_pos;
            r_hits_out   <= n_hits_out;
            r_rval       <= n_rval;
            o_is_empty   <= (n_occ == '0);
            o_item_count <= csol_pkg::ITEM_W'(n_occ);
            o_is_full    <= (n_occ == csol_pkg::CNT_W'(csol_pkg::CAPACITY));
        end
    end

    assign o_ok         = r_ok;
    assign o_position   = r_pos;
    assign o_hit_count  = r_hits_out;
    assign o_read_value = r_rval;

`ifndef ASSERT_OFF
    a_occ_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= csol_pkg::CNT_W'(csol_pkg::CAPACITY))
        else $error("fill count exceeds capacity");
`endif

endmodule

@@ hw/rtl/count_ordered_self_organizing_list_top.sv @@
`timescale 1ns / 1ps
// Top level of the count-ordered self-organizing list.
// Instantiates csol_ctrl and csol_datapath; uses csol_pkg.

// The block keeps a list of up to csol_pkg::CAPACITY signed 64-bit keys, each
// with a saturating 32-bit hit counter, ordered so that counts never increase
// toward the back. Each input item carries an opcode (insert, remove, search,
// clear, read slot) and produces exactly one result item. Insert, remove,
// clear, read and unused opcodes pass through acceptance and execution: the
// acceptance edge registers the parallel key compare across all cells, and
// the execution edge performs the operation and loads the result register.
// Search adds a counter fetch state between the two, because the matched
// entry's counter is read through the single cell read port and incremented
// in a state of its own before the move. The block takes one item at a time;
// the next item is accepted once the current one has executed, while its
// result may still wait in the output register. If that register is still
// full when an item is ready to execute, execution waits until the result is
// taken. Entry cells are not cleared at reset; only the fill count is, so no
// read ever sees them.

module count_ordered_self_organizing_list_top (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic        [csol_pkg::OP_W-1:0]     i_opcode,
    input  logic signed [csol_pkg::KEY_W-1:0]    i_key,
    input  logic        [csol_pkg::SLOT_W-1:0]   i_slot_index,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic                                 o_ok,
    output logic        [csol_pkg::POS_W-1:0]    o_position,
    output logic        [csol_pkg::HIT_W-1:0]    o_hit_count,
    output logic signed [csol_pkg::KEY_W-1:0]    o_read_value,
    output logic                                 o_is_empty,
    output logic        [csol_pkg::ITEM_W-1:0]   o_item_count,
    output logic                                 o_is_full
);

    // Command and status between the controller and the datapath.
    csol_pkg::t_dp_cmd dp_cmd;
    csol_pkg::t_dp_sts dp_sts;

    // The controller sequences accept, counter fetch and execute, and owns the
    // handshake on both channels.
    csol_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_cmd   (dp_cmd),
        .i_sts   (dp_sts)
    );

    // The datapath holds the cells, compares keys, reorders entries and
    // registers the result fields.
    csol_datapath u_datapath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (dp_cmd),
        .o_sts        (dp_sts),
        .i_opcode     (i_opcode),
        .i_key        (i_key),
        .i_slot_index (i_slot_index),
        .o_ok         (o_ok),
        .o_position   (o_position),
        .o_hit_count  (o_hit_count),
        .o_read_value (o_read_value),
        .o_is_empty   (o_is_empty),
        .o_item_count (o_item_count),
        .o_is_full    (o_is_full)
    );

endmodule
